// ===== design/rate_monotonic_tick_scheduler_core_assert.svh =====
// Assertion macros for the rate monotonic tick scheduler
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_CORE_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_CORE_ASSERT_SVH

// Implication checked on every edge outside reset
`define RMTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define RMTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rmts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_pkg
// Types and constants shared by the scheduler modules, and the bound table.
// ----------------------------------------------------------------------------
package rmts_pkg;

    localparam int MAX_TABLE_TASKS_DEF  = 16;
    localparam int TICK_FIELD_WIDTH_DEF = 16;
    localparam int TERM_W               = 17;
    localparam int SUM_W                = 21;
    localparam logic [TERM_W-1:0] TERM_MAX = 17'h1FFFF;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  task_index;
        logic [15:0] exec_time;
        logic [15:0] period_ticks;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  running_task;
        logic        idle;
        logic        job_done;
        logic        deadline_miss;
        logic [15:0] missed_mask;
        logic [20:0] utilization_q16;
        logic        schedulable;
        logic [31:0] current_time;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD_WR,
        ST_SUM,
        ST_CHECK_DONE,
        ST_RELEASE,
        ST_PICK,
        ST_RUN,
        ST_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_step;
        logic load_wr;
        logic scan_clr;
        logic scan_step;
        logic sum_acc;
        logic release_step;
        logic pick_step;
        logic run_apply;
        logic fin_load;
        logic fin_check;
        logic fin_tick;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic div_last;
        logic scan_last;
        logic load_ok;
    } t_stat;

    // floor(65536 * n * (2^(1/n) - 1)), index n-1
    function automatic logic [16:0] ll_bound(input logic [3:0] idx);
        logic [16:0] b;
        case (idx)
            4'd0:  b = 17'd65536;
            4'd1:  b = 17'd54291;
            4'd2:  b = 17'd51102;
            4'd3:  b = 17'd49599;
            4'd4:  b = 17'd48725;
            4'd5:  b = 17'd48154;
            4'd6:  b = 17'd47751;
            4'd7:  b = 17'd47452;
            4'd8:  b = 17'd47221;
            4'd9:  b = 17'd47037;
            4'd10: b = 17'd46887;
            4'd11: b = 17'd46763;
            4'd12: b = 17'd46658;
            4'd13: b = 17'd46569;
            4'd14: b = 17'd46492;
            default: b = 17'd46424;
        endcase
        return b;
    endfunction

endpackage

// ===== design/rmts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_ctrl
// Sequencer for load, tick and check operations.
// ----------------------------------------------------------------------------
module rmts_ctrl
    import rmts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_op,
    input  logic     i_out_busy,
    input  t_stat    i_stat,
    output logic     o_in_stall,
    output t_cmd     o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_TICK) begin
                        n_state = ST_RELEASE;
                    end else if (i_op == OP_CHECK) begin
                        n_state = ST_SUM;
                    end else if (i_op == OP_LOAD) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_DIV:        if (i_stat.div_last) n_state = ST_LOAD_WR;
            ST_LOAD_WR:    n_state = ST_OUT;
            ST_SUM:        if (i_stat.scan_last) n_state = ST_CHECK_DONE;
            ST_CHECK_DONE: n_state = ST_OUT;
            ST_RELEASE:    if (i_stat.scan_last) n_state = ST_PICK;
            ST_PICK:       if (i_stat.scan_last) n_state = ST_RUN;
            ST_RUN:        n_state = ST_OUT;
            ST_OUT:        if (!i_out_busy) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.capture  = i_in_valid;
                o_cmd.scan_clr = i_in_valid;
                o_cmd.div_start = i_in_valid;
                o_cmd.fin_load = i_in_valid && (i_op == OP_NOP);
            end
            ST_DIV:        o_cmd.div_step = 1'b1;
            ST_LOAD_WR: begin
                o_cmd.load_wr  = 1'b1;
                o_cmd.fin_load = 1'b1;
            end
            ST_SUM:        o_cmd.sum_acc = 1'b1;
            ST_CHECK_DONE: o_cmd.fin_check = 1'b1;
            ST_RELEASE: begin
                o_cmd.release_step = 1'b1;
                o_cmd.scan_clr     = i_stat.scan_last;
            end
            ST_PICK:       o_cmd.pick_step = 1'b1;
            ST_RUN: begin
                o_cmd.run_apply = 1'b1;
                o_cmd.fin_tick  = 1'b1;
            end
            default: ;
        endcase
        o_cmd.scan_step = o_cmd.sum_acc | o_cmd.release_step | o_cmd.pick_step;
    end

    `include "rate_monotonic_tick_scheduler_core_assert.svh"

    `RMTS_ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_state != ST_IDLE, o_in_stall, "stall low while busy")
    `RMTS_ASSERT_NEXT(a_run_to_out, i_clk, i_rst_n, r_state == ST_RUN, r_state == ST_OUT, "run not followed by out")
    `RMTS_ASSERT_IMPL(a_one_scan, i_clk, i_rst_n, o_cmd.scan_step, $onehot({o_cmd.sum_acc, o_cmd.release_step, o_cmd.pick_step}), "scan commands overlap")

endmodule

// ===== design/rmts_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_dp
// Task table, restoring divider, scan unit and result register.
// ----------------------------------------------------------------------------
module rmts_dp
    import rmts_pkg::*;
#(
    parameter int MAX_TABLE_TASKS  = MAX_TABLE_TASKS_DEF,
    parameter int TICK_FIELD_WIDTH = TICK_FIELD_WIDTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  t_cmd      i_cmd,
    input  logic      i_out_stall,
    output t_stat     o_stat,
    output logic      o_out_busy,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int TW    = TICK_FIELD_WIDTH;
    localparam int LIM   = (MAX_TABLE_TASKS < 16) ? MAX_TABLE_TASKS : 16;
    localparam int IW    = (MAX_TABLE_TASKS > 1) ? $clog2(MAX_TABLE_TASKS) : 1;
    localparam int DIV_W = 32;
    localparam int DCW   = $clog2(DIV_W);

    logic [TW-1:0]     r_period [MAX_TABLE_TASKS];
    logic [TW-1:0]     r_exec   [MAX_TABLE_TASKS];
    logic [TW-1:0]     r_phase  [MAX_TABLE_TASKS];
    logic [TW-1:0]     r_rem    [MAX_TABLE_TASKS];
    logic [TERM_W-1:0] r_term   [MAX_TABLE_TASKS];
    logic [31:0]       r_time;
    logic [4:0]        r_count;
    t_in_item          r_item;

    // Divider state
    logic [DIV_W-1:0] r_quo;
    logic [16:0]      r_remd;
    logic [DCW-1:0]   r_dcnt;

    // Scan state
    logic [3:0]       r_scan;
    logic [SUM_W-1:0] r_sum;
    logic [15:0]      r_mask;
    logic             r_found;
    logic [3:0]       r_best;
    logic [TW-1:0]    r_best_per;

    logic r_oval;
    t_out_item r_out;
    t_out_item n_out;
    logic      w_fin;

    logic [3:0] w_n_m1;
    logic [4:0] w_cnt_lim;
    logic [IW-1:0] w_sidx;
    logic [IW-1:0] w_bidx;
    logic [IW-1:0] w_lidx;
    logic [17:0]   w_trial;
    logic          w_load_in;

    // Clamp active count to 1..LIM
    always_comb begin
        w_cnt_lim = r_count;
        if (r_count == 5'd0) w_cnt_lim = 5'd1;
        if (r_count > 5'(LIM)) w_cnt_lim = 5'(LIM);
        w_n_m1 = 4'(w_cnt_lim - 5'd1);
    end

    assign w_sidx    = IW'(r_scan);
    assign w_bidx    = IW'(r_best);
    assign w_lidx    = IW'(r_item.task_index);
    assign w_load_in = ({1'b0, r_item.task_index} < 5'(MAX_TABLE_TASKS)) ||
                       (MAX_TABLE_TASKS >= 16);
    assign w_trial   = {r_remd, r_quo[DIV_W-1]} - {2'b0, r_item.period_ticks};

    assign o_stat.div_last  = (r_dcnt == DCW'(DIV_W - 1));
    assign o_stat.scan_last = (r_scan == w_n_m1);
    assign o_stat.load_ok   = w_load_in;

    // Configuration and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd1;
            r_time  <= '0;
        end else begin
            if (i_cfg_we) r_count <= i_cfg_wdata;
            if (i_cmd.fin_tick) r_time <= r_time + 32'd1;
        end
    end

    // Capture item; run divider one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_item;
        if (i_cmd.div_start) begin
            r_quo  <= {i_item.exec_time, 16'd0};
            r_remd <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + DCW'(1);
            if (!w_trial[17]) begin
                r_remd <= w_trial[16:0];
                r_quo  <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_remd <= {r_remd[15:0], r_quo[DIV_W-1]};
                r_quo  <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    // Scan counter and accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + 4'd1;
        end
        if (i_cmd.capture) begin
            r_sum   <= '0;
            r_mask  <= '0;
            r_found <= 1'b0;
            r_best  <= '0;
        end else begin
            if (i_cmd.sum_acc) r_sum <= r_sum + SUM_W'(r_term[w_sidx]);
            if (i_cmd.release_step && r_phase[w_sidx] == '0 && r_rem[w_sidx] != '0) begin
                r_mask[r_scan] <= 1'b1;
            end
            if (i_cmd.pick_step && r_rem[w_sidx] != '0 &&
                (!r_found || r_period[w_sidx] < r_best_per)) begin
                r_found    <= 1'b1;
                r_best     <= r_scan;
                r_best_per <= r_period[w_sidx];
            end
        end
    end

    // Table: reset-cleared phase, work and term; stored times written on load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TABLE_TASKS; k++) begin
                r_phase[k] <= '0;
                r_rem[k]   <= '0;
                r_term[k]  <= '0;
            end
        end else if (i_cmd.load_wr && w_load_in) begin
            r_phase[w_lidx] <= '0;
            r_rem[w_lidx]   <= '0;
            if (r_item.period_ticks == 16'd0 || r_quo[DIV_W-1:TERM_W] != '0) begin
                r_term[w_lidx] <= TERM_MAX;
            end else begin
                r_term[w_lidx] <= r_quo[TERM_W-1:0];
            end
        end else if (i_cmd.release_step) begin
            if (r_phase[w_sidx] == '0) begin
                r_rem[w_sidx]   <= r_exec[w_sidx];
                r_phase[w_sidx] <= (r_period[w_sidx] == '0) ? '0
                                   : r_period[w_sidx] - TW'(1);
            end else begin
                r_phase[w_sidx] <= r_phase[w_sidx] - TW'(1);
            end
        end else if (i_cmd.run_apply && r_found) begin
            r_rem[w_bidx] <= r_rem[w_bidx] - TW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && w_load_in) begin
            r_exec[w_lidx]   <= TW'(r_item.exec_time);
            r_period[w_lidx] <= TW'(r_item.period_ticks);
        end
    end

    assign w_fin = i_cmd.fin_load || i_cmd.fin_check || i_cmd.fin_tick;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (w_fin) begin
            r_oval <= 1'b1;
        end else if (!i_out_stall) begin
            r_oval <= 1'b0;
        end
    end

    // Assemble the next result
    always_comb begin
        n_out              = '0;
        n_out.idle         = 1'b1;
        n_out.current_time = r_time;
        if (i_cmd.fin_check) begin
            n_out.utilization_q16 = r_sum;
            n_out.schedulable     = (r_sum <= SUM_W'(ll_bound(w_n_m1)));
        end
        if (i_cmd.fin_tick) begin
            n_out.missed_mask   = r_mask;
            n_out.deadline_miss = (r_mask != '0);
            if (r_found) begin
                n_out.idle         = 1'b0;
                n_out.running_task = r_best;
                n_out.job_done     = (r_rem[w_bidx] == TW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_out <= n_out;
        end
    end

    assign o_out_busy  = r_oval && i_out_stall;
    assign o_out_valid = r_oval;
    assign o_out_item  = r_out;

    `include "rate_monotonic_tick_scheduler_core_assert.svh"

    `RMTS_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, w_n_m1 < 4'(LIM) || LIM == 16, "active count out of range")
    `RMTS_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, r_oval && i_out_stall && !i_cmd.fin_tick && !i_cmd.fin_load && !i_cmd.fin_check, r_oval && $stable(r_out), "result lost under stall")
    `RMTS_ASSERT_NEXT(a_time_step, i_clk, i_rst_n, i_cmd.fin_tick, r_time == $past(r_time) + 32'd1, "tick count not advanced")

endmodule

// ===== design/rate_monotonic_tick_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler_core
// Preemptive rate monotonic tick scheduler with utilization check.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                      Payload
// in       input      i_in_valid / o_in_stall        t_in_item
// out      output     o_out_valid / i_out_stall      t_out_item
// cfg      input      i_cfg_we                       task_count (5 bits)
//
// Load: the restoring divider produces one quotient bit per cycle, then the entry is written.
// Tick: two passes over n active tasks (release, then pick). Check: one summing pass.
// One item at a time; a result is held in the output register under stall.
// Synchronous reset clears the state and the phase, work and term entries.
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler_core
    import rmts_pkg::*;
#(
    parameter int MAX_TABLE_TASKS  = MAX_TABLE_TASKS_DEF,
    parameter int TICK_FIELD_WIDTH = TICK_FIELD_WIDTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [4:0] i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_out_busy;

    rmts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_item.op),
        .i_out_busy (w_out_busy),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    rmts_dp #(
        .MAX_TABLE_TASKS  (MAX_TABLE_TASKS),
        .TICK_FIELD_WIDTH (TICK_FIELD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_busy  (w_out_busy),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rate monotonic tick scheduler. Task loads,
// ticks, utilization checks and no-ops are driven over the valid/stall input
// channel. A scoreboard keeps its own task table and tick counter, and works
// out the result of every transfer. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import rmts_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int CYCLE_CAP  = 600000;
    localparam int SETTLE     = 48;
    localparam int HOLD_LEN   = 400;
    localparam int MAX_REPORT = 10;

    // Scheduler table and tick counter, with the queue of pending results
    class rm_scoreboard;
        bit [15:0] period_tab[16];
        bit [15:0] exec_tab[16];
        bit [15:0] phase_tab[16];
        bit [15:0] work_tab[16];
        bit [16:0] term_tab[16];
        bit [31:0] tick_now;
        bit [4:0]  task_count;
        bit [16:0] bound_tab[16];
        t_out_item pending_q[$];
        int        mismatches;

        function new();
            bound_tab = '{17'd65536, 17'd54291, 17'd51102, 17'd49599,
                          17'd48725, 17'd48154, 17'd47751, 17'd47452,
                          17'd47221, 17'd47037, 17'd46887, 17'd46763,
                          17'd46658, 17'd46569, 17'd46492, 17'd46424};
            task_count = 5'd1;
            tick_now   = '0;
            mismatches = 0;
            foreach (phase_tab[i]) begin
                phase_tab[i] = '0;
                work_tab[i]  = '0;
                term_tab[i]  = '0;
                period_tab[i] = '0;
                exec_tab[i]  = '0;
            end
        endfunction

        function void set_count(bit [4:0] v);
            task_count = v;
        endfunction

        // Work out the result of one accepted input transfer
        function void note_input(t_in_item it);
            t_out_item r;
            int        n;
            bit [32:0] q;
            bit [20:0] sum;
            bit        found;
            int        best;
            r = '0;
            r.idle = 1'b1;
            r.current_time = tick_now;
            n = (task_count == 0) ? 1 : (task_count > 16 ? 16 : int'(task_count));
            if (it.op == OP_LOAD) begin
                if (it.period_ticks == 0) begin
                    term_tab[it.task_index] = TERM_MAX;
                end else begin
                    q = {it.exec_time, 16'h0} / it.period_ticks;
                    term_tab[it.task_index] = (q > TERM_MAX) ? TERM_MAX : q[16:0];
                end
                exec_tab[it.task_index]   = it.exec_time;
                period_tab[it.task_index] = it.period_ticks;
                phase_tab[it.task_index]  = '0;
                work_tab[it.task_index]   = '0;
            end else if (it.op == OP_CHECK) begin
                sum = '0;
                for (int i = 0; i < n; i++) sum += term_tab[i];
                r.utilization_q16 = sum;
                r.schedulable = (sum <= bound_tab[n-1]);
            end else if (it.op == OP_TICK) begin
                // release jobs and flag misses
                for (int i = 0; i < n; i++) begin
                    if (phase_tab[i] == 0) begin
                        if (work_tab[i] != 0) r.missed_mask[i] = 1'b1;
                        work_tab[i]  = exec_tab[i];
                        phase_tab[i] = (period_tab[i] == 0) ? 16'd0 : period_tab[i] - 16'd1;
                    end else begin
                        phase_tab[i] = phase_tab[i] - 16'd1;
                    end
                end
                // pick the ready task with the shortest period
                found = 1'b0;
                best = 0;
                for (int i = 0; i < n; i++) begin
                    if (work_tab[i] != 0 && (!found || period_tab[i] < period_tab[best])) begin
                        best = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    r.idle = 1'b0;
                    r.running_task = best[3:0];
                    work_tab[best] = work_tab[best] - 16'd1;
                    r.job_done = (work_tab[best] == 0);
                end
                r.deadline_miss = (r.missed_mask != 0);
                tick_now = tick_now + 1;
            end
            pending_q.push_back(r);
        endfunction

        function bit field_ok(string name, bit [31:0] e, bit [31:0] a);
            if (e !== a) begin
                if (mismatches < MAX_REPORT)
                    $display("mismatch %s: expected %0d got %0d", name, e, a);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(t_out_item got);
            t_out_item e;
            bit        ok;
            if (pending_q.size() == 0) begin
                if (mismatches < MAX_REPORT) $display("unexpected result %h", got);
                mismatches++;
                return;
            end
            e = pending_q.pop_front();
            ok = 1'b1;
            ok &= field_ok("running_task", e.running_task, got.running_task);
            ok &= field_ok("idle", e.idle, got.idle);
            ok &= field_ok("job_done", e.job_done, got.job_done);
            ok &= field_ok("deadline_miss", e.deadline_miss, got.deadline_miss);
            ok &= field_ok("missed_mask", e.missed_mask, got.missed_mask);
            ok &= field_ok("utilization_q16", e.utilization_q16, got.utilization_q16);
            ok &= field_ok("schedulable", e.schedulable, got.schedulable);
            ok &= field_ok("current_time", e.current_time, got.current_time);
            if (!ok) mismatches++;
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_item;
    logic       i_cfg_we;
    logic [4:0] i_cfg_wdata;

    rm_scoreboard sched_sb;
    int           cycle_count;
    bit           hold_req;
    bit           calm;

    rate_monotonic_tick_scheduler_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    function int draw_gap();
        if (calm || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 13);
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(bit [1:0] op, bit [3:0] idx, bit [15:0] ex, bit [15:0] per);
        t_in_item it;
        int       gap;
        it.op = op;
        it.task_index = idx;
        it.exec_time = ex;
        it.period_ticks = per;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        sched_sb.note_input(it);
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sched_sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write task_count once the block has gone quiet
    task automatic write_count(bit [4:0] v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sched_sb.set_count(v);
    endtask

    // Receive results; hold off for a long stretch on request
    initial begin
        t_out_item got;
        int        gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                gap = draw_gap();
                if (gap > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            @(negedge i_clk);
            while (!o_out_valid) @(negedge i_clk);
            got = o_out_item;
            sched_sb.check_result(got);
            @(posedge i_clk);
        end
    end

    initial begin
        bit [1:0]  op;
        bit [4:0]  cnt;
        bit [15:0] ex;
        bit [15:0] per;
        int        sent;
        int        pick;
        sched_sb    = new();
        i_clk       = 1'b0;
        cycle_count = 0;
        hold_req    = 1'b0;
        calm        = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: load every slot, several with edge values, then check, tick, no-op, reload slot 0 and tick
        send_item(OP_LOAD, 4'd0, 16'd1, 16'd1);
        send_item(OP_LOAD, 4'd1, 16'hFFFF, 16'd1);
        send_item(OP_LOAD, 4'd2, 16'hFFFF, 16'hFFFF);
        send_item(OP_LOAD, 4'd3, 16'd1, 16'hFFFF);
        send_item(OP_LOAD, 4'd4, 16'd0, 16'd5);
        send_item(OP_LOAD, 4'd5, 16'd3, 16'd0);
        for (int i = 6; i < 16; i++)
            send_item(OP_LOAD, i[3:0], 16'd1 + i[15:0], 16'd4 * i[15:0]);
        send_item(OP_CHECK, 4'd0, 16'd0, 16'd0);
        repeat (3) send_item(OP_TICK, 4'd0, 16'd0, 16'd0);
        send_item(OP_NOP, 4'hF, 16'hFFFF, 16'hFFFF);
        send_item(OP_LOAD, 4'd0, 16'd2, 16'd3);
        repeat (3) send_item(OP_TICK, 4'd0, 16'd0, 16'd0);

        // Random phases under varied task counts
        sent = 0;
        for (int ph = 0; sent < 1080; ph++) begin
            case (ph % 8)
                0: cnt = 5'd16;
                1: cnt = 5'd1;
                2: cnt = 5'd0;
                3: cnt = 5'd31;
                default: cnt = 5'($urandom_range(1, 20));
            endcase
            write_count(cnt);
            calm = (ph % 5 == 3);
            if (ph == 2) hold_req = 1'b1;
            // well-formed loads for a random subset of the slots
            for (int i = 0; i < 16; i++) begin
                if ($urandom_range(0, 2) != 0) begin
                    per = 16'($urandom_range(1, 24));
                    ex  = 16'($urandom_range(1, 4));
                    send_item(OP_LOAD, i[3:0], ex, per);
                    sent++;
                end
            end
            for (int k = 0; k < 90; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    op = OP_TICK;
                end else if (pick < 82) begin
                    op = OP_CHECK;
                end else if (pick < 85) begin
                    op = OP_NOP;
                end else begin
                    op = OP_LOAD;
                end
                if (op == OP_LOAD && $urandom_range(0, 4) == 0) begin
                    ex  = 16'($urandom);
                    per = 16'($urandom);
                end else begin
                    ex  = 16'($urandom_range(0, 5));
                    per = 16'($urandom_range(0, 30));
                end
                send_item(op, 4'($urandom_range(0, 15)), ex, per);
                sent++;
            end
        end

        // Wait for the tail, bounded by the cycle limit
        drain_results();
        if (sched_sb.mismatches == 0 && sched_sb.pending_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
